/* rtl/core/srconv_pkg.sv */
// Shared types, register indexes and the decimal power table for the
// sensor reading conversion core. No dependencies.
package srconv_pkg;

   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 10;
   localparam int unsigned RawW      = 8;
   localparam int unsigned XW        = 9;
   localparam int unsigned ProdW     = 19;
   localparam int unsigned PowW      = 27;
   localparam int unsigned OffsW     = 34;
   localparam int unsigned MantW     = 45;
   localparam int unsigned ExpW      = 5;
   localparam int unsigned RspDataW  = 56;

   localparam logic [CsrIdxW-1:0] CSR_IDX_MULT     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_IDX_OFFSET   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_IDX_OFF_EXP  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_IDX_RES_EXP  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_IDX_FORMAT   = 3'd4;

   typedef enum logic [1:0] {
      FMT_UNSIGNED  = 2'd0,
      FMT_ONES_COMP = 2'd1,
      FMT_TWOS_COMP = 2'd2
   } fmt_type;

   typedef struct packed {
      logic signed [9:0] mult;
      logic signed [9:0] offset;
      logic signed [3:0] off_exp;
      logic signed [3:0] res_exp;
      logic [1:0]        format;
   } cfg_type;

   typedef struct packed {
      logic signed [ProdW-1:0] prod;
      logic signed [OffsW-1:0] offs;
   } front_type;

   typedef struct packed {
      logic signed [MantW-1:0] scaled;
      logic signed [OffsW-1:0] offs;
   } scale_type;

   typedef struct packed {
      logic signed [ExpW-1:0]  dec_exp;
      logic signed [MantW-1:0] mant;
   } result_type;

   function automatic logic [PowW-1:0] pow10(input logic [3:0] n);
      logic [PowW-1:0] p;
      unique case (n)
         4'd0:    p = 27'd1;
         4'd1:    p = 27'd10;
         4'd2:    p = 27'd100;
         4'd3:    p = 27'd1000;
         4'd4:    p = 27'd10000;
         4'd5:    p = 27'd100000;
         4'd6:    p = 27'd1000000;
         4'd7:    p = 27'd10000000;
         4'd8:    p = 27'd100000000;
         default: p = 27'd0;
      endcase
      return p;
   endfunction

endpackage

/* rtl/core/srconv_front.sv */
// Stage one: decode the raw byte per format, form m*x and the offset term.
// Depends on srconv_pkg.
module srconv_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [srconv_pkg::RawW-1:0] raw,
   input  srconv_pkg::cfg_type         cfg,
   output logic                        out_valid,
   output srconv_pkg::front_type       out_data
);

   logic signed [srconv_pkg::XW-1:0]          x;
   logic [srconv_pkg::PowW-1:0]               off_pow;
   logic signed [srconv_pkg::ProdW+18:0]      offs_full;
   logic                                      valid_ff;
   srconv_pkg::front_type                     data_ff;
   srconv_pkg::front_type                     data_in;

   always_comb begin
      unique case (cfg.format)
         srconv_pkg::FMT_TWOS_COMP: x = $signed({raw[7], raw});
         srconv_pkg::FMT_ONES_COMP: x = raw[7] ? $signed({1'b1, raw} + 9'd1)
                                               : $signed({1'b0, raw});
         default:                   x = $signed({1'b0, raw});
      endcase
      off_pow = srconv_pkg::pow10(cfg.off_exp[3] ? 4'd0 : {1'b0, cfg.off_exp[2:0]});
      offs_full = cfg.offset * $signed({1'b0, off_pow});
      data_in.prod = cfg.mult * x;
      data_in.offs = offs_full[srconv_pkg::OffsW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/srconv_scale.sv */
// Stage two: scale m*x by ten to the negated offset exponent when that exponent is negative.
// Depends on srconv_pkg.
module srconv_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  srconv_pkg::front_type in_data,
   input  srconv_pkg::cfg_type   cfg,
   output logic                  out_valid,
   output srconv_pkg::scale_type out_data
);

   logic [srconv_pkg::PowW-1:0]                          scale_pow;
   logic signed [srconv_pkg::ProdW+srconv_pkg::PowW:0]   scaled_full;
   logic                                                 valid_ff;
   srconv_pkg::scale_type                                data_ff;
   srconv_pkg::scale_type                                data_in;

   always_comb begin
      scale_pow = srconv_pkg::pow10(cfg.off_exp[3] ? 4'(-cfg.off_exp) : 4'd0);
      scaled_full = in_data.prod * $signed({1'b0, scale_pow});
      data_in.scaled = scaled_full[srconv_pkg::MantW-1:0];
      data_in.offs = in_data.offs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/srconv_sum.sv */
// Stage three: add the offset term and form the decimal exponent.
// Depends on srconv_pkg.
module srconv_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  srconv_pkg::scale_type  in_data,
   input  srconv_pkg::cfg_type    cfg,
   output logic                   out_valid,
   output srconv_pkg::result_type out_data
);

   logic                   valid_ff;
   srconv_pkg::result_type data_ff;
   srconv_pkg::result_type data_in;

   always_comb begin
      data_in.mant = in_data.scaled
         + {{(srconv_pkg::MantW-srconv_pkg::OffsW){in_data.offs[srconv_pkg::OffsW-1]}},
            in_data.offs};
      data_in.dec_exp = {cfg.res_exp[3], cfg.res_exp}
         + (cfg.off_exp[3] ? {cfg.off_exp[3], cfg.off_exp} : 5'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/srconv_skid.sv */
// Output skid buffer with a registered ready toward the pipeline.
// Depends on srconv_pkg.
module srconv_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  srconv_pkg::result_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output srconv_pkg::result_type out_data
);

   logic                   main_valid_ff;
   logic                   skid_valid_ff;
   srconv_pkg::result_type main_data_ff;
   srconv_pkg::result_type skid_data_ff;
   logic                   pop;
   logic                   push;

   assign pop  = !main_valid_ff || out_ready;
   assign push = in_valid && !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

/* rtl/core/sensor_reading_conversion_core.sv */
// Linear sensor reading conversion: raw byte to exact decimal mantissa and
// exponent, y = (m*x + b*10^bexp)*10^rexp. Accepts one request every cycle
// while req_tready is high. A result passes through decode and multiply,
// power-of-ten scaling, offset add and the output buffer before it is offered.
// The output buffer holds two results, so req_tready is a registered signal.
// Write the configuration registers only while no request is in flight.
// Depends on srconv_pkg, srconv_front, srconv_scale, srconv_sum, srconv_skid.
module sensor_reading_conversion_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srconv_pkg::RawW-1:0]         req_tdata,  // [7:0] raw_reading
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [44:0] result_mantissa, [49:45] result_decimal_exponent, [55:50] zero
   output logic [srconv_pkg::RspDataW-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srconv_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [srconv_pkg::CsrDataW-1:0]     csr_data
);

   srconv_pkg::cfg_type    cfg_ff;
   logic                   enable;
   logic                   front_valid;
   srconv_pkg::front_type  front_data;
   logic                   scale_valid;
   srconv_pkg::scale_type  scale_data;
   logic                   sum_valid;
   srconv_pkg::result_type sum_data;
   srconv_pkg::result_type rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mult    <= 10'sd1;
         cfg_ff.offset  <= 10'sd0;
         cfg_ff.off_exp <= 4'sd0;
         cfg_ff.res_exp <= 4'sd0;
         cfg_ff.format  <= srconv_pkg::FMT_UNSIGNED;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srconv_pkg::CSR_IDX_MULT:    cfg_ff.mult    <= csr_data;
            srconv_pkg::CSR_IDX_OFFSET:  cfg_ff.offset  <= csr_data;
            srconv_pkg::CSR_IDX_OFF_EXP: cfg_ff.off_exp <= csr_data[3:0];
            srconv_pkg::CSR_IDX_RES_EXP: cfg_ff.res_exp <= csr_data[3:0];
            srconv_pkg::CSR_IDX_FORMAT:  cfg_ff.format  <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = enable;

   srconv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .raw       (req_tdata),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   srconv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .cfg       (cfg_ff),
      .out_valid (scale_valid),
      .out_data  (scale_data)
   );

   srconv_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (scale_valid),
      .in_data   (scale_data),
      .cfg       (cfg_ff),
      .out_valid (sum_valid),
      .out_data  (sum_data)
   );

   srconv_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (enable),
      .in_data   (sum_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {6'd0, rsp_data};

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("pipeline stalled without a pending result");

   a_request_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 req_tready ##1 req_tready ##1 req_tready
      |=> rsp_tvalid)
      else $error("accepted request did not reach the output");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:50] == 6'd0))
      else $error("result padding bits not zero");

endmodule
